[hdl/lpct_pkg.sv]
// Shared types and codes for the low-power compare timer.
`default_nettype none

package lpct_pkg;

	localparam int CMD_W      = 3;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_COUNT_W = 16;

	// command codes
	localparam logic [CMD_W-1:0] CMD_STEP    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ENABLE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_COUNT_MODE    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FREE_RUNNING  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PIN_POLARITY  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PIN_CHOICE    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PRESCALE_EXP  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_PRESCALE_BYP  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_IRQ_ENABLE    = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_COMPARE_VALUE = 3'd7;

	localparam logic [15:0] PRESCALE_FULL = 16'hFFFF;

	typedef struct packed {
		logic        count_mode;
		logic        free_running;
		logic        pin_polarity;
		logic [1:0]  pin_choice;
		logic [3:0]  prescale_exponent;
		logic        prescale_bypass;
		logic        irq_enable;
		logic [15:0] compare_value;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             clock_edge;
		logic [3:0]       pin_levels;
	} item_t;

	typedef struct packed {
		logic [OUT_COUNT_W-1:0] count_now;
		logic                   compare_flag;
		logic                   irq_request;
		logic                   running;
	} res_t;

endpackage

`default_nettype wire

[hdl/low_power_compare_timer.sv]
// Top level of the low-power compare timer and pulse counter.
// An accepted item waits in the input register until the result register is free.
// Throughput: one item per cycle while results are taken; the input and result registers
// part the two channels, and the state update is a single add and compare on the counter.
// Reset: arst_n clears run state, counter, prescaler, flag, pin history and both
// valid bits at once; configuration returns to its reset values (bypass set).
`default_nettype none

module low_power_compare_timer #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write port
	input  wire logic                              cfg_we,
	input  wire logic [lpct_pkg::REG_IDX_W-1:0]    cfg_index,
	input  wire logic [lpct_pkg::CFG_DATA_W-1:0]   cfg_data,
	// item channel
	input  wire logic                              item_valid,
	output logic                                   item_ready,
	input  wire logic [lpct_pkg::CMD_W-1:0]        command,
	input  wire logic                              clock_edge,
	input  wire logic [3:0]                        pin_levels,
	// result channel
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output logic [lpct_pkg::OUT_COUNT_W-1:0]       count_now,
	output logic                                   compare_flag,
	output logic                                   irq_request,
	output logic                                   running
);

	lpct_pkg::cfg_t  cfg_q;
	lpct_pkg::item_t item_s1;
	logic            valid_s1;
	lpct_pkg::res_t  res_comb;
	lpct_pkg::res_t  res_s2;
	logic            valid_s2;

	logic            res_free;
	logic            fire;
	logic            accept;

	// Configuration registers: written at once, no handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count_mode        <= 1'b0;
			cfg_q.free_running      <= 1'b0;
			cfg_q.pin_polarity      <= 1'b0;
			cfg_q.pin_choice        <= 2'd0;
			cfg_q.prescale_exponent <= 4'd0;
			cfg_q.prescale_bypass   <= 1'b1;
			cfg_q.irq_enable        <= 1'b0;
			cfg_q.compare_value     <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lpct_pkg::REG_COUNT_MODE:    cfg_q.count_mode        <= cfg_data[0];
				lpct_pkg::REG_FREE_RUNNING:  cfg_q.free_running      <= cfg_data[0];
				lpct_pkg::REG_PIN_POLARITY:  cfg_q.pin_polarity      <= cfg_data[0];
				lpct_pkg::REG_PIN_CHOICE:    cfg_q.pin_choice        <= cfg_data[1:0];
				lpct_pkg::REG_PRESCALE_EXP:  cfg_q.prescale_exponent <= cfg_data[3:0];
				lpct_pkg::REG_PRESCALE_BYP:  cfg_q.prescale_bypass   <= cfg_data[0];
				lpct_pkg::REG_IRQ_ENABLE:    cfg_q.irq_enable        <= cfg_data[0];
				lpct_pkg::REG_COMPARE_VALUE: cfg_q.compare_value     <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Handshake: the result register frees when empty or taken this cycle;
	// the input stage advances into it whenever it is free.
	assign res_free   = !valid_s2 || result_ready;
	assign fire       = valid_s1 && res_free;
	assign item_ready = !valid_s1 || fire;
	assign accept     = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the item payload until the input stage hands it on.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.command    <= command;
			item_s1.clock_edge <= clock_edge;
			item_s1.pin_levels <= pin_levels;
		end
	end

	lpct_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.cfg   (cfg_q),
		.item  (item_s1),
		.res   (res_comb)
	);

	// Result register: drop valid once taken, load a new result on fire.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_comb;
		end
	end

	assign result_valid = valid_s2;
	assign count_now    = res_s2.count_now;
	assign compare_flag = res_s2.compare_flag;
	assign irq_request  = res_s2.irq_request;
	assign running      = res_s2.running;

endmodule

`default_nettype wire

[hdl/lpct_core.sv]
// Timer state and the per-item update: prescaler, pin edge detect, counter, flag.
`default_nettype none

module lpct_core #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  wire lpct_pkg::cfg_t  cfg,
	input  wire lpct_pkg::item_t item,
	output lpct_pkg::res_t       res
);

	logic                  run_q, run_n;
	logic [COUNT_BITS-1:0] main_count_q, main_count_n;
	logic [15:0]           prescale_q, prescale_n;
	logic                  match_q, match_n;
	logic                  last_pin_q;

	logic                  pin_now;
	logic                  rising;
	logic [15:0]           term;
	logic [COUNT_BITS-1:0] cmp;
	logic                  hit;
	logic                  tick;
	logic                  pre_wrap;
	logic [COUNT_BITS-1:0] bumped;

	assign pin_now  = item.pin_levels[cfg.pin_choice] ^ cfg.pin_polarity;
	assign rising   = pin_now & ~last_pin_q;
	// terminal prescaler value is 2^(exp+1)-1
	assign term     = lpct_pkg::PRESCALE_FULL >> (4'd15 - cfg.prescale_exponent);
	assign pre_wrap = (prescale_q >= term);
	assign cmp      = COUNT_BITS'(cfg.compare_value);
	assign hit      = (main_count_q == cmp);
	assign bumped   = (hit && !cfg.free_running) ? '0 : main_count_q + 1'b1;

	always_comb begin
		tick = 1'b0;
		if (cfg.count_mode) begin
			tick = rising;
		end else if (item.clock_edge) begin
			tick = cfg.prescale_bypass | pre_wrap;
		end
	end

	always_comb begin
		run_n        = run_q;
		main_count_n = main_count_q;
		prescale_n   = prescale_q;
		match_n      = match_q;
		unique case (item.command)
			lpct_pkg::CMD_STEP: begin
				if (run_q) begin
					// prescaler only advances in time mode without bypass
					if (!cfg.count_mode && item.clock_edge && !cfg.prescale_bypass) begin
						prescale_n = pre_wrap ? 16'd0 : prescale_q + 16'd1;
					end
					if (tick) begin
						main_count_n = bumped;
						match_n      = match_q | hit;
					end
				end
			end
			lpct_pkg::CMD_ENABLE: begin
				run_n = 1'b1;
			end
			lpct_pkg::CMD_DISABLE: begin
				run_n        = 1'b0;
				main_count_n = '0;
				prescale_n   = 16'd0;
				match_n      = 1'b0;
			end
			lpct_pkg::CMD_CLEAR: begin
				match_n = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q        <= 1'b0;
			main_count_q <= '0;
			prescale_q   <= 16'd0;
			match_q      <= 1'b0;
			last_pin_q   <= 1'b0;
		end else if (fire) begin
			run_q        <= run_n;
			main_count_q <= main_count_n;
			prescale_q   <= prescale_n;
			match_q      <= match_n;
			last_pin_q   <= pin_now;
		end
	end

	assign res.count_now    = lpct_pkg::OUT_COUNT_W'(main_count_n);
	assign res.compare_flag = match_n;
	assign res.irq_request  = match_n & cfg.irq_enable;
	assign res.running      = run_n;

endmodule

`default_nettype wire

[hdl/lpct_checker.sv]
// Port-level checks for the low-power compare timer, bound to the top level.
`default_nettype none

module lpct_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic [15:0] count_now,
	input wire logic        compare_flag,
	input wire logic        irq_request,
	input wire logic        running
);

	// a stalled result keeps valid and its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(count_now)
			&& $stable(compare_flag) && $stable(irq_request) && $stable(running))
		else $error("result changed while stalled");

	// interrupt request only with the flag set
	a_irq_needs_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && irq_request |-> compare_flag)
		else $error("irq_request without compare_flag");

	// a stopped timer was never started or was disabled: counter and flag are clear
	a_stopped_clear: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !running |-> count_now == 16'd0 && !compare_flag)
		else $error("stopped timer shows count or flag");

endmodule

bind low_power_compare_timer lpct_checker u_lpct_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.count_now   (count_now),
	.compare_flag(compare_flag),
	.irq_request (irq_request),
	.running     (running)
);

`default_nettype wire
